FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: design/i2cm_pkg.sv
// Package: types, codes and helpers of the I2C register-access master.
`default_nettype none

package i2cm_pkg;

	localparam int unsigned PHASE_TIMER_BITS = 8;
	localparam int unsigned PT_CALC_BITS = (PHASE_TIMER_BITS > 8) ? PHASE_TIMER_BITS : 8;
	localparam int unsigned PT_MAX = (1 << PHASE_TIMER_BITS) - 1;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_READ   = 2'd2,
		OP_BURST  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_BUS_BUSY  = 3'd1,
		STS_BUS_ERROR = 3'd2,
		STS_NO_ACK    = 3'd3,
		STS_ZERO_CNT  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CFG_FAST_MODE  = 2'd0,
		CFG_SLOW_TICKS = 2'd1,
		CFG_FAST_TICKS = 2'd2
	} cfg_index_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_START1, ST_START2, ST_START3,
		ST_RSTART1, ST_RSTART2, ST_RSTART3,
		ST_TX_LOW, ST_TX_DATA, ST_TX_HIGH,
		ST_ACK_LOW, ST_ACK_REL, ST_ACK_HIGH, ST_ACK_END,
		ST_RX_LOW, ST_RX_HIGH,
		ST_MACK_LOW, ST_MACK_SDA, ST_MACK_HIGH, ST_MACK_END,
		ST_STOP1, ST_STOP2, ST_STOP3, ST_STOP4
	} seq_state_t;

	typedef enum logic [2:0] {
		STG_DEV, STG_REG, STG_DATA, STG_RDADDR, STG_FAIL
	} byte_stage_t;

	typedef struct packed {
		logic       fast_mode;
		logic [7:0] slow_phase_ticks;
		logic [7:0] fast_phase_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] device_address;
		logic [7:0] register_address;
		logic [7:0] write_byte;
		logic [7:0] read_count;
		logic       sda_sample;
	} cmd_item_t;

	typedef struct packed {
		logic       scl_drive;
		logic       sda_drive;
		logic       busy_res;
		logic       byte_valid;
		logic [7:0] read_data;
		logic       byte_last;
		logic       done_res;
		logic [2:0] status;
	} res_item_t;

	// Ticks loaded at the start of a phase: zero counts as one, and the
	// value saturates to what the phase timer can hold.
	function automatic logic [PHASE_TIMER_BITS-1:0] phase_load(input cfg_t cfg);
		logic [7:0]              t;
		logic [PT_CALC_BITS-1:0] tw;
		t = cfg.fast_mode ? cfg.fast_phase_ticks : cfg.slow_phase_ticks;
		if (t == 8'd0)
			t = 8'd1;
		tw = PT_CALC_BITS'(t);
		if (tw > PT_CALC_BITS'(PT_MAX))
			tw = PT_CALC_BITS'(PT_MAX);
		return tw[PHASE_TIMER_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: design/i2cm_cmd_if.sv
// Command/tick channel interface.
`default_nettype none

interface i2cm_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] device_address;
	logic [7:0] register_address;
	logic [7:0] write_byte;
	logic [7:0] read_count;
	logic       sda_sample;

	modport source (
		output valid, opcode, device_address, register_address, write_byte,
			read_count, sda_sample,
		input  ready
	);
	modport sink (
		input  valid, opcode, device_address, register_address, write_byte,
			read_count, sda_sample,
		output ready
	);
endinterface

`default_nettype wire

FILE: design/i2cm_res_if.sv
// Result channel interface.
`default_nettype none

interface i2cm_res_if;
	logic       valid;
	logic       ready;
	logic       scl_drive;
	logic       sda_drive;
	logic       busy_res;
	logic       byte_valid;
	logic [7:0] read_data;
	logic       byte_last;
	logic       done_res;
	logic [2:0] status;

	modport source (
		output valid, scl_drive, sda_drive, busy_res, byte_valid, read_data,
			byte_last, done_res, status,
		input  ready
	);
	modport sink (
		input  valid, scl_drive, sda_drive, busy_res, byte_valid, read_data,
			byte_last, done_res, status,
		output ready
	);
endinterface

`default_nettype wire

FILE: design/i2cm_cfg_regs.sv
// Configuration register file: phase tick counts and speed select.
`default_nettype none

module i2cm_cfg_regs
	import i2cm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wen,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_wdata,
	output cfg_t            cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fast_mode        <= 1'b0;
			cfg_q.slow_phase_ticks <= 8'd20;
			cfg_q.fast_phase_ticks <= 8'd4;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_FAST_MODE:  cfg_q.fast_mode        <= cfg_wdata[0];
				CFG_SLOW_TICKS: cfg_q.slow_phase_ticks <= cfg_wdata;
				CFG_FAST_TICKS: cfg_q.fast_phase_ticks <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: design/i2cm_seq.sv
// Bus sequencer: state registers and the one-step next-state logic.
`default_nettype none

module i2cm_seq
	import i2cm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  cmd_item_t item,
	input  cfg_t      cfg,
	output res_item_t res
);

	seq_state_t                  st_q, st_n;
	byte_stage_t                 stg_q, stg_n;
	logic [PHASE_TIMER_BITS-1:0] tmr_q, tmr_n;
	logic [3:0]                  bc_q, bc_n;
	logic [7:0]                  sh_q, sh_n;
	logic [7:0]                  br_q, br_n;
	logic [1:0]                  kind_q, kind_n;
	logic [7:0]                  dev_q, dev_n;
	logic [7:0]                  reg_q, reg_n;
	logic [7:0]                  wdat_q, wdat_n;
	logic                        scl_q, scl_n;
	logic                        sda_q, sda_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			stg_q  <= STG_DEV;
			tmr_q  <= '0;
			bc_q   <= '0;
			sh_q   <= '0;
			br_q   <= '0;
			kind_q <= '0;
			dev_q  <= '0;
			reg_q  <= '0;
			wdat_q <= '0;
			scl_q  <= 1'b1;
			sda_q  <= 1'b1;
		end else if (step) begin
			st_q   <= st_n;
			stg_q  <= stg_n;
			tmr_q  <= tmr_n;
			bc_q   <= bc_n;
			sh_q   <= sh_n;
			br_q   <= br_n;
			kind_q <= kind_n;
			dev_q  <= dev_n;
			reg_q  <= reg_n;
			wdat_q <= wdat_n;
			scl_q  <= scl_n;
			sda_q  <= sda_n;
		end
	end

	always_comb begin
		logic       entering;
		logic       valid;
		logic [7:0] data;
		logic       last;
		logic       done;
		status_t    sts;

		st_n     = st_q;
		stg_n    = stg_q;
		tmr_n    = tmr_q;
		bc_n     = bc_q;
		sh_n     = sh_q;
		br_n     = br_q;
		kind_n   = kind_q;
		dev_n    = dev_q;
		reg_n    = reg_q;
		wdat_n   = wdat_q;
		scl_n    = scl_q;
		sda_n    = sda_q;
		entering = 1'b0;
		valid    = 1'b0;
		data     = 8'd0;
		last     = 1'b0;
		done     = 1'b0;
		sts      = STS_OK;

		if (st_q == ST_IDLE) begin
			if (item.opcode != OP_TICK) begin
				if (item.opcode == OP_BURST && item.read_count == 8'd0) begin
					done = 1'b1;
					sts  = STS_ZERO_CNT;
				end else begin
					kind_n   = item.opcode;
					dev_n    = item.device_address;
					reg_n    = item.register_address;
					wdat_n   = item.write_byte;
					br_n     = (item.opcode == OP_BURST) ? item.read_count : 8'd1;
					stg_n    = STG_DEV;
					bc_n     = '0;
					sh_n     = '0;
					st_n     = ST_START1;
					entering = 1'b1;
				end
			end
		end else if (tmr_q > PHASE_TIMER_BITS'(1)) begin
			tmr_n = tmr_q - PHASE_TIMER_BITS'(1);
		end else begin
			tmr_n    = '0;
			entering = 1'b1;
			case (st_q)
				ST_START1: begin
					if (!item.sda_sample) begin
						st_n = ST_IDLE; entering = 1'b0; done = 1'b1; sts = STS_BUS_BUSY;
					end else begin
						st_n = ST_START2;
					end
				end
				ST_START2: begin
					if (item.sda_sample) begin
						st_n = ST_IDLE; entering = 1'b0; done = 1'b1; sts = STS_BUS_ERROR;
					end else begin
						st_n = ST_START3;
					end
				end
				ST_START3: begin
					sh_n = dev_q; bc_n = '0; stg_n = STG_DEV; st_n = ST_TX_LOW;
				end
				ST_RSTART1: st_n = ST_RSTART2;
				ST_RSTART2: st_n = ST_RSTART3;
				ST_RSTART3: begin
					sh_n = dev_q + 8'd1; bc_n = '0; stg_n = STG_RDADDR; st_n = ST_TX_LOW;
				end
				ST_TX_LOW:  st_n = ST_TX_DATA;
				ST_TX_DATA: st_n = ST_TX_HIGH;
				ST_TX_HIGH: begin
					bc_n = bc_q + 4'd1;
					st_n = (bc_n < 4'd8) ? ST_TX_LOW : ST_ACK_LOW;
				end
				ST_ACK_LOW: st_n = ST_ACK_REL;
				ST_ACK_REL: st_n = ST_ACK_HIGH;
				ST_ACK_HIGH: begin
					// only the device address acknowledge is checked
					if (stg_q == STG_DEV && item.sda_sample)
						stg_n = STG_FAIL;
					st_n = ST_ACK_END;
				end
				ST_ACK_END: begin
					case (stg_q)
						STG_DEV: begin
							sh_n = reg_q; bc_n = '0; stg_n = STG_REG; st_n = ST_TX_LOW;
						end
						STG_REG: begin
							if (kind_q == OP_WRITE) begin
								sh_n = wdat_q; bc_n = '0; stg_n = STG_DATA; st_n = ST_TX_LOW;
							end else begin
								st_n = ST_RSTART1;
							end
						end
						STG_RDADDR: begin
							bc_n = '0; sh_n = '0; st_n = ST_RX_LOW;
						end
						default: st_n = ST_STOP1;
					endcase
				end
				ST_RX_LOW: st_n = ST_RX_HIGH;
				ST_RX_HIGH: begin
					sh_n = {sh_q[6:0], item.sda_sample};
					bc_n = bc_q + 4'd1;
					if (bc_n < 4'd8) begin
						st_n = ST_RX_LOW;
					end else begin
						valid = 1'b1;
						data  = sh_n;
						last  = (br_q <= 8'd1);
						br_n  = last ? 8'd0 : br_q - 8'd1;
						st_n  = ST_MACK_LOW;
					end
				end
				ST_MACK_LOW:  st_n = ST_MACK_SDA;
				ST_MACK_SDA:  st_n = ST_MACK_HIGH;
				ST_MACK_HIGH: st_n = ST_MACK_END;
				ST_MACK_END: begin
					if (br_q == 8'd0) begin
						st_n = ST_STOP1;
					end else begin
						bc_n = '0; sh_n = '0; st_n = ST_RX_LOW;
					end
				end
				ST_STOP1: st_n = ST_STOP2;
				ST_STOP2: st_n = ST_STOP3;
				ST_STOP3: st_n = ST_STOP4;
				default: begin
					st_n     = ST_IDLE;
					entering = 1'b0;
					done     = 1'b1;
					sts      = (stg_q == STG_FAIL) ? STS_NO_ACK : STS_OK;
				end
			endcase
		end

		// pin levels and phase reload on entry to a new phase
		if (entering) begin
			tmr_n = phase_load(cfg);
			case (st_n)
				ST_START1, ST_RSTART1: begin
					sda_n = 1'b1; scl_n = 1'b1;
				end
				ST_START2, ST_RSTART2, ST_START3, ST_RSTART3, ST_STOP2: sda_n = 1'b0;
				ST_TX_DATA: begin
					sda_n = sh_n[7];
					sh_n  = {sh_n[6:0], 1'b0};
				end
				ST_TX_HIGH, ST_ACK_HIGH, ST_RX_HIGH, ST_MACK_HIGH, ST_STOP3: scl_n = 1'b1;
				ST_ACK_REL, ST_STOP4: sda_n = 1'b1;
				ST_RX_LOW: begin
					scl_n = 1'b0; sda_n = 1'b1;
				end
				ST_MACK_SDA: sda_n = (br_n == 8'd0);
				default: scl_n = 1'b0;
			endcase
		end

		res.scl_drive  = scl_n;
		res.sda_drive  = sda_n;
		res.busy_res   = (st_n != ST_IDLE);
		res.byte_valid = valid;
		res.read_data  = data;
		res.byte_last  = last;
		res.done_res   = done;
		res.status     = sts;
	end

endmodule

`default_nettype wire

FILE: design/i2cm_out_stage.sv
// Result register: holds one finished result until the sink takes it.
`default_nettype none

module i2cm_out_stage
	import i2cm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  load,
	input  res_item_t  res_d,
	output logic       free,
	i2cm_res_if.source res
);

	res_item_t res_q;
	logic      vld_q;

	assign free = !vld_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (load)
			vld_q <= 1'b1;
		else if (res.ready)
			vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_d;
	end

	assign res.valid      = vld_q;
	assign res.scl_drive  = res_q.scl_drive;
	assign res.sda_drive  = res_q.sda_drive;
	assign res.busy_res   = res_q.busy_res;
	assign res.byte_valid = res_q.byte_valid;
	assign res.read_data  = res_q.read_data;
	assign res.byte_last  = res_q.byte_last;
	assign res.done_res   = res_q.done_res;
	assign res.status     = res_q.status;

endmodule

`default_nettype wire

FILE: design/i2c_master_register_access.sv
// Top level of the I2C register-access master.
//
// Channel   Dir  Contents
// cmd       in   opcode, addresses, write byte, read count, sampled SDA
// res       out  SCL/SDA drive, busy, read byte with flags, done, status
// cfg       in   write enable, register index, write data (no read-back)
//
// Accepts one transaction per clock while the result is not stalled. An accepted
// transaction waits in the input register until the result register is free; its
// sequencer step then lands in the result register, which offers the result.
// A stalled result blocks the input register; one more transaction is still
// taken while the input register is empty.
// Reset is asynchronous: the bus is released (SCL and SDA high) and the
// sequencer is idle.
`default_nettype none

module i2c_master_register_access
	import i2cm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	i2cm_cmd_if.sink        cmd,
	i2cm_res_if.source      res,
	input  wire logic       cfg_wen,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_wdata
);

	cfg_t      cfg;
	cmd_item_t item_s1;
	logic      vld_s1;
	logic      out_free;
	logic      adv;
	res_item_t step_res;

	i2cm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign adv       = vld_s1 && out_free;
	assign cmd.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (cmd.ready)
			vld_s1 <= cmd.valid;
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1.opcode           <= cmd.opcode;
			item_s1.device_address   <= cmd.device_address;
			item_s1.register_address <= cmd.register_address;
			item_s1.write_byte       <= cmd.write_byte;
			item_s1.read_count       <= cmd.read_count;
			item_s1.sda_sample       <= cmd.sda_sample;
		end
	end

	i2cm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (step_res)
	);

	i2cm_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv),
		.res_d  (step_res),
		.free   (out_free),
		.res    (res)
	);

endmodule

`default_nettype wire

FILE: design/i2cm_checker.sv
// Port-level checker for the I2C master, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module i2cm_checker
	import i2cm_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic       busy_res,
	input wire logic       byte_valid,
	input wire logic [7:0] read_data,
	input wire logic       byte_last,
	input wire logic       done_res,
	input wire logic [2:0] status
);

	`CHK_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	`CHK_NEXT(a_res_stable, clk, arst_n, res_valid && !res_ready, $stable(read_data) && $stable(status))
	`CHK_IMPLY(a_status_quiet, clk, arst_n, res_valid && !done_res, status == STS_OK)
	`CHK_IMPLY(a_byte_quiet, clk, arst_n, res_valid && !byte_valid, read_data == 8'd0 && !byte_last)
	`CHK_IMPLY(a_done_idle, clk, arst_n, res_valid && done_res, !busy_res && !byte_valid)

endmodule

bind i2c_master_register_access i2cm_checker u_i2cm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.busy_res   (res.busy_res),
	.byte_valid (res.byte_valid),
	.read_data  (res.read_data),
	.byte_last  (res.byte_last),
	.done_res   (res.done_res),
	.status     (res.status)
);

`default_nettype wire
